// ===== sv/mfmt_pkg.sv =====
// Package for the multi-turn motor feedback tracker.
// Holds slot count, field widths, register indexes, reset values and the slot entry type.
// No dependencies.
package mfmt_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    localparam int ID_W    = 11;
    localparam int ANGLE_W = 16;
    localparam int WORD_W  = 16;
    localparam int TEMP_W  = 8;
    localparam int TURN_W  = 16;
    localparam int POS_W   = 35;
    localparam int OSLOT_W = 3;

    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 112;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ID_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW  = 2'd2;

    localparam logic [ID_W-1:0] ID_BASE_RST = 11'd513;
    localparam logic [7:0]      MASK_RST    = 8'hFF;
    localparam logic [15:0]     WINDOW_RST  = 16'd200;

    // Angle jump that counts as a wrap of the encoder.
    localparam logic signed [16:0] WRAP_HI = 17'sd6400;
    localparam logic signed [16:0] WRAP_LO = -17'sd6400;

    // Q10 degrees per encoder count is 45; one turn is 8192 counts.
    localparam int LIN_W      = 30;
    localparam int PROD_W     = 36;
    localparam logic signed [PROD_W-1:0] Q10_PER_COUNT = 36'sd45;

    localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

    typedef struct packed {
        logic [ANGLE_W-1:0]       prev;
        logic signed [TURN_W-1:0] turns;
        logic [ANGLE_W-1:0]       start;
    } t_slot_entry;

endpackage

// ===== sv/motor_feedback_multiturn_tracker.sv =====
// Multi-turn angle tracker for motor feedback frames, top level.
// Pipeline: the slot read and stage one registers, stage two, then the output register.
// Throughput: one frame per cycle while the output is not stalled; set by the slot
//   memory read-modify-write, its registered read bridged by forwarding the write-back.
// Reset: configuration returns to its defaults, frame count clears, and per-slot
//   valid flags clear at once so every slot reads as zero; no clearing pass.
module motor_feedback_multiturn_tracker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [mfmt_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mfmt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Frame input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata from bit 0: frame_id[10:0], angle_word[26:11], speed_word[42:27],
    // current_word[58:43], temperature_byte[66:59], zero pad [71:67].
    input  logic [mfmt_pkg::S_DATA_W-1:0]   s_axis_tdata,
    // Result output stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata from bit 0: slot[2:0], angle[18:3], speed[34:19], current[50:35],
    // temperature[58:51], turn_count[74:59], position_q10[109:75], zero pad [111:110].
    output logic [mfmt_pkg::M_DATA_W-1:0]   m_axis_tdata,
    // tuser: matched.
    output logic                            m_axis_tuser
);
    import mfmt_pkg::*;

    // Configuration registers. Writes are only expected while the pipeline is idle,
    // so the port is always ready.
    logic [ID_W-1:0] r_id_base;
    logic [7:0]      r_mask;
    logic [15:0]     r_window;
    logic [15:0]     r_frames;
    logic [15:0]     n_frames;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_id_base <= ID_BASE_RST;
            r_mask    <= MASK_RST;
            r_window  <= WINDOW_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_ID_BASE: r_id_base <= i_cfg_data[ID_W-1:0];
                REG_MASK:    r_mask    <= i_cfg_data[7:0];
                REG_WINDOW:  r_window  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    // Unpack the input transaction.
    logic [ID_W-1:0]    in_id;
    logic [ANGLE_W-1:0] in_angle;
    logic [WORD_W-1:0]  in_speed;
    logic [WORD_W-1:0]  in_current;
    logic [TEMP_W-1:0]  in_temp;

    assign in_id      = s_axis_tdata[10:0];
    assign in_angle   = s_axis_tdata[26:11];
    assign in_speed   = s_axis_tdata[42:27];
    assign in_current = s_axis_tdata[58:43];
    assign in_temp    = s_axis_tdata[66:59];

    // Pipeline flow control. Each stage moves when the stage after it is empty or moving,
    // so a new frame enters even while a result is waiting on the output.
    logic r_s1_v;
    logic r_s2_v;
    logic r_out_v;
    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_accept;
    logic s1_commit;

    assign out_ready     = !r_out_v || m_axis_tready;
    assign s2_ready      = !r_s2_v || out_ready;
    assign s1_ready      = !r_s1_v || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_accept     = s_axis_tvalid && s1_ready;

    // Slot lookup. The index wraps modulo 2048 by the subtraction width.
    logic [ID_W-1:0]   idx;
    logic              in_matched;
    logic              in_capture;
    logic [SLOT_W-1:0] rd_addr;

    assign idx        = in_id - r_id_base;
    assign in_matched = ({21'd0, idx} < NUM_SLOTS);
    assign rd_addr    = idx[SLOT_W-1:0];
    assign n_frames   = (r_frames == 16'hFFFF) ? r_frames : r_frames + 16'd1;
    // Capture of the start angle uses the frame count including this frame.
    assign in_capture = (n_frames < r_window) && (idx[ID_W-1:3] == '0) && r_mask[idx[2:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames <= '0;
        end else if (in_accept) begin
            r_frames <= n_frames;
        end
    end

    // Slot memory with a valid flag for each entry; an entry never written reads as zero.
    t_slot_entry       mem [NUM_SLOTS];
    logic [NUM_SLOTS-1:0] r_vld;
    t_slot_entry       r_rd;
    logic              r_rd_vld;
    t_slot_entry       wr_data;
    logic [SLOT_W-1:0] r_s1_addr;

    always_ff @(posedge i_clk) begin
        if (s1_commit) begin
            mem[r_s1_addr] <= wr_data;
        end
    end

    // The read happens only on acceptance so a stalled first stage keeps its data.
    // A write-back to the same slot at the same edge is forwarded into the read register.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            if (s1_commit && (r_s1_addr == rd_addr)) begin
                r_rd <= wr_data;
            end else begin
                r_rd <= mem[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (s1_commit) begin
                r_vld[r_s1_addr] <= 1'b1;
            end
            if (in_accept) begin
                r_rd_vld <= (s1_commit && (r_s1_addr == rd_addr)) || r_vld[rd_addr];
            end
        end
    end

    // Stage one: frame payload alongside the slot read.
    logic               r_s1_matched;
    logic               r_s1_capture;
    logic [OSLOT_W-1:0] r_s1_slot;
    logic [ANGLE_W-1:0] r_s1_angle;
    logic [WORD_W-1:0]  r_s1_speed;
    logic [WORD_W-1:0]  r_s1_current;
    logic [TEMP_W-1:0]  r_s1_temp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else if (s1_ready) begin
            r_s1_v <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_matched <= in_matched;
            r_s1_capture <= in_capture;
            r_s1_slot    <= idx[OSLOT_W-1:0];
            r_s1_addr    <= rd_addr;
            r_s1_angle   <= in_angle;
            r_s1_speed   <= in_speed;
            r_s1_current <= in_current;
            r_s1_temp    <= in_temp;
        end
    end

    // Turn tracking: a large drop means the encoder wrapped forward, a large rise backward.
    logic [ANGLE_W-1:0]       cur_prev;
    logic signed [TURN_W-1:0] cur_turns;
    logic [ANGLE_W-1:0]       cur_start;
    logic [ANGLE_W-1:0]       start_eff;
    logic signed [16:0]       delta;
    logic signed [16:0]       span;
    logic signed [TURN_W-1:0] turns_new;
    logic signed [TURN_W-1:0] s1_tc;
    logic signed [LIN_W-1:0]  s1_lin;

    assign s1_commit = r_s1_v && s2_ready && r_s1_matched;

    always_comb begin
        cur_prev  = r_rd_vld ? r_rd.prev  : '0;
        cur_turns = r_rd_vld ? r_rd.turns : '0;
        cur_start = r_rd_vld ? r_rd.start : '0;
        start_eff = r_s1_capture ? cur_prev : cur_start;
        delta     = $signed({1'b0, r_s1_angle}) - $signed({1'b0, cur_prev});
        span      = $signed({1'b0, r_s1_angle}) - $signed({1'b0, start_eff});
        turns_new = cur_turns;
        if (delta < WRAP_LO) begin
            if (cur_turns != TURN_MAX) begin
                turns_new = cur_turns + 16'sd1;
            end
        end else if (delta > WRAP_HI) begin
            if (cur_turns != TURN_MIN) begin
                turns_new = cur_turns - 16'sd1;
            end
        end
        wr_data.prev  = r_s1_angle;
        wr_data.turns = turns_new;
        wr_data.start = start_eff;
        // Position in encoder counts: turns times 8192 plus the offset from the start angle.
        if (r_s1_matched) begin
            s1_tc  = turns_new;
            s1_lin = $signed({turns_new[TURN_W-1], turns_new, 13'd0})
                   + $signed({{(LIN_W-17){span[16]}}, span});
        end else begin
            s1_tc  = '0;
            s1_lin = '0;
        end
    end

    // Stage two: scale counts to Q10 degrees on the way into the output register.
    logic                     r_s2_matched;
    logic [OSLOT_W-1:0]       r_s2_slot;
    logic [ANGLE_W-1:0]       r_s2_angle;
    logic [WORD_W-1:0]        r_s2_speed;
    logic [WORD_W-1:0]        r_s2_current;
    logic [TEMP_W-1:0]        r_s2_temp;
    logic signed [TURN_W-1:0] r_s2_tc;
    logic signed [LIN_W-1:0]  r_s2_lin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else if (s2_ready) begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_v && s2_ready) begin
            r_s2_matched <= r_s1_matched;
            r_s2_slot    <= r_s1_matched ? r_s1_slot : '0;
            r_s2_angle   <= r_s1_angle;
            r_s2_speed   <= r_s1_speed;
            r_s2_current <= r_s1_current;
            r_s2_temp    <= r_s1_temp;
            r_s2_tc      <= s1_tc;
            r_s2_lin     <= s1_lin;
        end
    end

    logic signed [PROD_W-1:0] prod;

    assign prod = $signed({{(PROD_W-LIN_W){r_s2_lin[LIN_W-1]}}, r_s2_lin}) * Q10_PER_COUNT;

    logic                     r_out_matched;
    logic [OSLOT_W-1:0]       r_out_slot;
    logic [ANGLE_W-1:0]       r_out_angle;
    logic [WORD_W-1:0]        r_out_speed;
    logic [WORD_W-1:0]        r_out_current;
    logic [TEMP_W-1:0]        r_out_temp;
    logic signed [TURN_W-1:0] r_out_tc;
    logic signed [POS_W-1:0]  r_out_pos;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_ready) begin
            r_out_v <= r_s2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s2_v && out_ready) begin
            r_out_matched <= r_s2_matched;
            r_out_slot    <= r_s2_slot;
            r_out_angle   <= r_s2_angle;
            r_out_speed   <= r_s2_speed;
            r_out_current <= r_s2_current;
            r_out_temp    <= r_s2_temp;
            r_out_tc      <= r_s2_tc;
            r_out_pos     <= prod[POS_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tuser  = r_out_matched;
    assign m_axis_tdata  = {2'b00, r_out_pos, r_out_tc, r_out_temp, r_out_current,
                            r_out_speed, r_out_angle, r_out_slot};

`ifndef SYNTHESIS
    // An unmatched frame never carries a turn count or a position.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && !r_out_matched |-> (r_out_tc == '0) && (r_out_pos == '0))
        else $error("unmatched result with nonzero turn count or position");

    // A write-back marks its slot valid for the following reads.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_commit |=> r_vld[$past(r_s1_addr)])
        else $error("slot not valid after write-back");

    // Input is held off only when every stage is full and the output is stalled.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_s1_v && r_s2_v && r_out_v && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // The frame counter only counts up.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> r_frames >= $past(r_frames))
        else $error("frame counter went backward");
`endif

endmodule

// ===== test/mfmt_tracker_sb_pkg.sv =====
// Checking package for the multi-turn motor feedback tracker testbench.
// Holds the frame and result types and the scoreboard class with its own slot predictor.
// Depends on mfmt_pkg for widths, slot count and register indexes.
package mfmt_tracker_sb_pkg;

    import mfmt_pkg::*;

    // Index that no register answers to; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    localparam int     WRAP_COUNTS       = 6400;
    localparam longint Q10_PER_TURN_DEG  = 368640;
    localparam longint Q10_PER_ENC_COUNT = 45;
    localparam int     TURNS_CEIL        = 32767;
    localparam int     TURNS_FLOOR       = -32768;

    typedef struct packed {
        logic [ID_W-1:0]          id;
        logic [ANGLE_W-1:0]       angle;
        logic signed [WORD_W-1:0] speed;
        logic signed [WORD_W-1:0] current;
        logic [TEMP_W-1:0]        temp;
    } t_feedback_frame;

    typedef struct packed {
        logic                     matched;
        logic [OSLOT_W-1:0]       slot;
        logic [ANGLE_W-1:0]       angle;
        logic signed [WORD_W-1:0] speed;
        logic signed [WORD_W-1:0] current;
        logic [TEMP_W-1:0]        temp;
        logic signed [TURN_W-1:0] turns;
        logic signed [POS_W-1:0]  position;
    } t_tracker_result;

    class t_turn_tracker_checker;
        logic [ID_W-1:0]          id_base;
        logic [7:0]               cap_mask;
        logic [15:0]              cap_window;
        logic [15:0]              frames_seen;
        logic [ANGLE_W-1:0]       last_angle [NUM_SLOTS];
        logic signed [TURN_W-1:0] turn_total [NUM_SLOTS];
        logic [ANGLE_W-1:0]       zero_angle [NUM_SLOTS];
        t_tracker_result          awaited [$];
        int                       mismatches;
        int                       results_checked;
        int                       slot_hits;

        function new();
            id_base     = ID_BASE_RST;
            cap_mask    = MASK_RST;
            cap_window  = WINDOW_RST;
            frames_seen = '0;
            for (int i = 0; i < NUM_SLOTS; i++) begin
                last_angle[i] = '0;
                turn_total[i] = '0;
                zero_angle[i] = '0;
            end
            mismatches      = 0;
            results_checked = 0;
            slot_hits       = 0;
        endfunction

        function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
            case (index)
                REG_ID_BASE: id_base    = value[ID_W-1:0];
                REG_MASK:    cap_mask   = value[7:0];
                REG_WINDOW:  cap_window = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        // Predicts the result of one accepted frame and queues it.
        function void note_frame(t_feedback_frame f);
            int              slot_idx;
            int              delta;
            longint          pos;
            t_tracker_result r;
            r         = '0;
            r.angle   = f.angle;
            r.speed   = f.speed;
            r.current = f.current;
            r.temp    = f.temp;
            slot_idx  = (int'(f.id) - int'(id_base)) & 32'h7FF;
            // The frame counter moves on every frame until it saturates, before the window test.
            if (frames_seen != 16'hFFFF)
                frames_seen++;
            if (slot_idx < NUM_SLOTS) begin
                slot_hits++;
                r.matched = 1'b1;
                r.slot    = slot_idx[OSLOT_W-1:0];
                if (frames_seen < cap_window && slot_idx < 8 && cap_mask[slot_idx[2:0]])
                    zero_angle[slot_idx] = last_angle[slot_idx];
                delta = int'(f.angle) - int'(last_angle[slot_idx]);
                if (delta < -WRAP_COUNTS) begin
                    if (turn_total[slot_idx] != TURNS_CEIL)
                        turn_total[slot_idx]++;
                end else if (delta > WRAP_COUNTS) begin
                    if (turn_total[slot_idx] != TURNS_FLOOR)
                        turn_total[slot_idx]--;
                end
                r.turns = turn_total[slot_idx];
                pos = longint'(turn_total[slot_idx]) * Q10_PER_TURN_DEG
                    + (longint'(f.angle) - longint'(zero_angle[slot_idx])) * Q10_PER_ENC_COUNT;
                r.position = pos[POS_W-1:0];
                last_angle[slot_idx] = f.angle;
            end
            awaited.push_back(r);
        endfunction

        function void check_result(t_tracker_result got);
            t_tracker_result want;
            if (awaited.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no frame pending: slot=%0d angle=%0d", $time,
                             got.slot, got.angle);
                return;
            end
            want = awaited.pop_front();
            results_checked++;
            if (got.matched !== want.matched || got.slot !== want.slot ||
                got.angle !== want.angle || got.speed !== want.speed ||
                got.current !== want.current || got.temp !== want.temp ||
                got.turns !== want.turns || got.position !== want.position) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: want m=%0d s=%0d a=%0d v=%0d i=%0d t=%0d n=%0d p=%0d",
                             $time, want.matched, want.slot, want.angle, want.speed,
                             want.current, want.temp, want.turns, want.position);
                    $display("%0t: got  m=%0d s=%0d a=%0d v=%0d i=%0d t=%0d n=%0d p=%0d",
                             $time, got.matched, got.slot, got.angle, got.speed,
                             got.current, got.temp, got.turns, got.position);
                end
            end
        endfunction
    endclass

endpackage

// ===== test/tb_top.sv =====
// Top-level testbench for the multi-turn motor feedback tracker.
// Drives frames and register writes, and checks every result against the scoreboard.
// Depends on mfmt_pkg, mfmt_tracker_sb_pkg and the tracker RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mfmt_pkg::*;
    import mfmt_tracker_sb_pkg::*;

    localparam int CYCLE_LIMIT     = 100_000;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int BURST_TURNS     = 20;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int IDLE_PERCENT    = 17;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_DATA_W-1:0]   s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_axis_tdata;
    logic                  m_axis_tuser;

    t_turn_tracker_checker tracker;

    // Idling switches for the two sides, and the receiver hold-off request.
    bit tx_gaps  = 1'b1;
    bit rx_gaps  = 1'b1;
    bit hold_req = 1'b0;
    int hold_left   = 0;
    int cycle_count = 0;
    int frames_sent = 0;
    int cfg_writes  = 0;

    // Stimulus-side copy of the identifier base and of the last angle sent to each slot,
    // used only to shape encoder-like angle sequences.
    logic [ID_W-1:0]    cur_base = ID_BASE_RST;
    logic [ANGLE_W-1:0] shaped_angle [NUM_SLOTS];

    motor_feedback_multiturn_tracker uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                     tracker.pending());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Receiver side. Ready changes on the falling edge. A hold-off request keeps ready low
    // for a long stretch so the pipeline fills and back-pressures the frame input.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req      = 1'b0;
                hold_left     = HOLD_OFF_CYCLES - 1;
                m_axis_tready = 1'b0;
            end else if (rx_gaps) begin
                m_axis_tready = ($urandom_range(0, 99) >= IDLE_PERCENT);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    // Every result transaction is unpacked and handed to the scoreboard.
    always @(posedge i_clk) begin
        t_tracker_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_tracker_result'({m_axis_tuser, m_axis_tdata[2:0], m_axis_tdata[18:3],
                                     m_axis_tdata[34:19], m_axis_tdata[50:35],
                                     m_axis_tdata[58:51], m_axis_tdata[74:59],
                                     m_axis_tdata[109:75]});
            tracker.check_result(got);
        end
    end

    // Offers one frame, starting and ending at a falling edge. Valid stays high on return
    // so back-to-back frames need no bubble.
    task automatic send_frame(t_feedback_frame f);
        int slot_idx;
        if (tx_gaps) begin
            while ($urandom_range(0, 99) < IDLE_PERCENT) begin
                s_axis_tvalid = 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {5'b0, f.temp, f.current, f.speed, f.angle, f.id};
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        tracker.note_frame(f);
        frames_sent++;
        slot_idx = (int'(f.id) - int'(cur_base)) & 32'h7FF;
        if (slot_idx < NUM_SLOTS)
            shaped_angle[slot_idx] = f.angle;
        @(negedge i_clk);
    endtask

    task automatic send(logic [ID_W-1:0] id, logic [ANGLE_W-1:0] ang, logic [WORD_W-1:0] spd,
                        logic [WORD_W-1:0] cur, logic [TEMP_W-1:0] tmp);
        t_feedback_frame f;
        f.id      = id;
        f.angle   = ang;
        f.speed   = spd;
        f.current = cur;
        f.temp    = tmp;
        send_frame(f);
    endtask

    // Most frames hit a configured slot with an encoder-like angle that walks around an
    // 8192-count turn, so wraps happen naturally. Some land exactly on or just past the
    // wrap threshold, and the rest are fully random angles or random identifiers.
    function automatic t_feedback_frame random_frame();
        t_feedback_frame f;
        int s;
        int pick;
        int step;
        f.id      = ID_W'($urandom_range(0, 2047));
        f.angle   = ANGLE_W'($urandom_range(0, 65535));
        f.speed   = WORD_W'($urandom_range(0, 65535));
        f.current = WORD_W'($urandom_range(0, 65535));
        f.temp    = TEMP_W'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) begin
            s    = $urandom_range(0, NUM_SLOTS - 1);
            f.id = cur_base + ID_W'(s);
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                step    = $urandom_range(0, 3000) - 1500;
                f.angle = ANGLE_W'((int'(shaped_angle[s]) + step) & 8191);
            end else if (pick < 85) begin
                case ($urandom_range(0, 3))
                    0:       step = WRAP_COUNTS;
                    1:       step = -WRAP_COUNTS;
                    2:       step = WRAP_COUNTS + 1;
                    default: step = -WRAP_COUNTS - 1;
                endcase
                f.angle = shaped_angle[s] + ANGLE_W'(step);
            end
        end
        return f;
    endfunction

    task automatic run_random(int count, bit with_hold_off);
        for (int i = 0; i < count; i++) begin
            send_frame(random_frame());
            if (with_hold_off && i == count / 2)
                hold_req = 1'b1;
        end
    endtask

    // Waits until every expected result has come back, with no frame offered, so a register
    // write finds the block idle.
    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = value;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.write_register(index, value);
        cfg_writes++;
        if (index == REG_ID_BASE)
            cur_base = value[ID_W-1:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        tracker = new();
        for (int i = 0; i < NUM_SLOTS; i++)
            shaped_angle[i] = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed frames under the reset configuration. Slot zero walks through a full
        // backward wrap, a forward wrap, a rise of exactly the threshold, a rise just past
        // it, a drop of exactly the threshold and a drop just past it.
        send(ID_BASE_RST, 16'd0, 16'h8000, 16'h7FFF, 8'd0);
        send(ID_BASE_RST, 16'hFFFF, 16'h7FFF, 16'h8000, 8'hFF);
        send(ID_BASE_RST, 16'd0, 16'd0, 16'd0, 8'h5A);
        send(ID_BASE_RST, 16'd6400, 16'hFFFF, 16'h0001, 8'hA5);
        send(ID_BASE_RST, 16'd12801, 16'h0001, 16'hFFFF, 8'd1);
        send(ID_BASE_RST, 16'd6401, 16'h1234, 16'h4321, 8'd2);
        send(ID_BASE_RST, 16'd0, 16'h8000, 16'h8000, 8'hFE);
        // One frame for each of the other slots, the last one at the largest angle.
        for (int s = 1; s < NUM_SLOTS - 1; s++)
            send(ID_BASE_RST + ID_W'(s), ANGLE_W'($urandom_range(0, 8191)),
                 WORD_W'($urandom_range(0, 65535)), WORD_W'($urandom_range(0, 65535)),
                 TEMP_W'($urandom_range(0, 255)));
        send(ID_BASE_RST + ID_W'(NUM_SLOTS - 1), 16'hFFFF, 16'h7FFF, 16'h7FFF, 8'hFF);
        // Identifiers outside the slot range: one past the top slot, one below the base,
        // and the two identifier extremes.
        send(ID_BASE_RST + ID_W'(NUM_SLOTS), 16'd1000, 16'd5, 16'd6, 8'd7);
        send(ID_BASE_RST - 11'd1, 16'd2000, 16'd8, 16'd9, 8'd10);
        send(11'd0, 16'hFFFF, 16'h8000, 16'h7FFF, 8'hFF);
        send(11'h7FF, 16'd0, 16'h7FFF, 16'h8000, 8'd0);

        // Reset configuration, with one long receiver hold-off in the middle.
        run_random(ITEMS_PER_PHASE, 1'b1);

        // Base at zero, every other slot may capture, but the window is closed.
        drain();
        write_reg(REG_ID_BASE, 16'd0);
        write_reg(REG_MASK, 16'h0055);
        write_reg(REG_WINDOW, 16'd0);
        run_random(ITEMS_PER_PHASE, 1'b0);

        // Base at the top so the slot range wraps past identifier zero; window wide open.
        drain();
        write_reg(REG_ID_BASE, 16'd2047);
        write_reg(REG_MASK, 16'h00AA);
        write_reg(REG_WINDOW, 16'hFFFF);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom_range(0, 65535)));
        run_random(ITEMS_PER_PHASE, 1'b0);

        // The capture window closes partway through this phase.
        drain();
        write_reg(REG_ID_BASE, 16'd2040);
        write_reg(REG_MASK, 16'h00FF);
        write_reg(REG_WINDOW, CFG_DATA_W'(frames_sent + 120));
        run_random(ITEMS_PER_PHASE, 1'b0);

        drain();
        write_reg(REG_ID_BASE, CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(REG_MASK, CFG_DATA_W'($urandom_range(0, 255)));
        write_reg(REG_WINDOW, CFG_DATA_W'($urandom_range(0, 65535)));
        run_random(ITEMS_PER_PHASE, 1'b0);

        drain();
        write_reg(REG_ID_BASE, 16'd1024);
        write_reg(REG_MASK, 16'd0);
        run_random(ITEMS_PER_PHASE, 1'b0);

        // Burst with no idling on either side. Three frames per turn: two rises at the threshold
        // and one large drop for slot 6, the reverse for slot 7. Slot 6 runs forward and slot 7
        // backward, so the same slot is updated on consecutive cycles.
        drain();
        write_reg(REG_ID_BASE, 16'd0);
        write_reg(REG_MASK, 16'h00FF);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        for (int k = 0; k < BURST_TURNS; k++) begin
            send(11'd6, 16'd0, WORD_W'(k), WORD_W'(-k), TEMP_W'(k));
            send(11'd6, 16'd6400, WORD_W'(k), WORD_W'(-k), TEMP_W'(k));
            send(11'd6, 16'd12800, WORD_W'(k), WORD_W'(-k), TEMP_W'(k));
        end
        for (int k = 0; k < BURST_TURNS; k++) begin
            send(11'd7, 16'd12800, WORD_W'(-k), WORD_W'(k), TEMP_W'(k));
            send(11'd7, 16'd6400, WORD_W'(-k), WORD_W'(k), TEMP_W'(k));
            send(11'd7, 16'd0, WORD_W'(-k), WORD_W'(k), TEMP_W'(k));
        end

        // The window opens fully again, so every slot captures on each frame.
        drain();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        write_reg(REG_WINDOW, 16'hFFFF);
        run_random(40, 1'b0);

        drain();
        repeat (20) @(posedge i_clk);

        $display("Summary: %0d frames sent, %0d results checked, %0d hit a slot, %0d writes.",
                 frames_sent, tracker.results_checked, tracker.slot_hits, cfg_writes);
        $display("Summary: base/mask/window extremes, wrap thresholds, a gap-free burst and a %0d-cycle receiver hold-off were exercised.",
                 HOLD_OFF_CYCLES);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", tracker.mismatches,
                     tracker.pending());
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
